[hw/rtl/projective_pixel_forward_warp_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the projective pixel forward warp
// Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_PIXEL_FORWARD_WARP_MACROS_SVH
`define PROJECTIVE_PIXEL_FORWARD_WARP_MACROS_SVH

// consequent holds in the same cycle
`define PPFW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the next cycle
`define PPFW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ppfw_pkg.sv]
// ----------------------------------------------------------------------------
// ppfw_pkg
// Types and constants shared by the projective pixel forward warp.
// ----------------------------------------------------------------------------
package ppfw_pkg;

	localparam int COORD_BITS      = 11;
	localparam int COEF_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int WORD_W          = 32;
	localparam int SIZE_W          = 12;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 4;
	// product of a coefficient and an unsigned coordinate
	localparam int PROD_W = WORD_W + COORD_BITS + 1;
	// sum of three terms
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;
	localparam int REM_W  = MAG_W + COORD_BITS;
	localparam int LIM_W  = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_XY    = 4'd0,
		REG_ROW0_T     = 4'd1,
		REG_ROW1_XY    = 4'd2,
		REG_ROW1_T     = 4'd3,
		REG_ROW2_XY    = 4'd4,
		REG_ROW2_T     = 4'd5,
		REG_OUT_WIDTH  = 4'd6,
		REG_OUT_HEIGHT = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic [WORD_W-1:0]     pixel_value;
	} src_pix_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] dest_x;
		logic [COORD_BITS-1:0] dest_y;
		logic [WORD_W-1:0]     dest_value;
		logic                  write_enable;
	} dst_pix_t;

	typedef struct packed {
		logic [63:0]       row0_xy;
		logic [WORD_W-1:0] row0_t;
		logic [63:0]       row1_xy;
		logic [WORD_W-1:0] row1_t;
		logic [63:0]       row2_xy;
		logic [WORD_W-1:0] row2_t;
		logic [SIZE_W-1:0] out_width;
		logic [SIZE_W-1:0] out_height;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [MAG_W-1:0]  nx_mag;
		logic [MAG_W-1:0]  ny_mag;
		logic [MAG_W-1:0]  d_mag;
		logic              negx;
		logic              negy;
		logic              wzero;
		logic              ovfx;
		logic              ovfy;
		logic [WORD_W-1:0] pix;
	} q_entry_t;

	// one stage of the restoring divider pair
	typedef struct packed {
		logic [REM_W-1:0]      rx;
		logic [REM_W-1:0]      ry;
		logic [COORD_BITS-1:0] qx;
		logic [COORD_BITS-1:0] qy;
		logic [MAG_W-1:0]      d;
		logic                  negx;
		logic                  negy;
		logic                  wzero;
		logic                  ovfx;
		logic                  ovfy;
		logic [WORD_W-1:0]     pix;
	} div_stage_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[hw/rtl/ppfw_front.sv]
// ----------------------------------------------------------------------------
// ppfw_front
// Multiplies, sums and classifies source pixels for the divider back end.
// ----------------------------------------------------------------------------
module ppfw_front import ppfw_pkg::*; #(
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     src_valid,
	output logic     src_stall,
	input  src_pix_t src,
	input  logic     q_full,
	output logic     push,
	output q_entry_t entry
);

	localparam logic [WORD_W-1:0] KEEP = ~((WORD_W'(1) << (WORD_W - COEF_BITS)) - WORD_W'(1));

	logic signed [WORD_W-1:0] h [9];
	logic signed [PROD_W-1:0] p_s1 [6];
	logic [WORD_W-1:0]        pix_s1, pix_s2;
	logic                     v_s1, v_s2;
	logic signed [SUM_W-1:0]  nx_s2, ny_s2, w_s2;
	logic                     adv;
	logic signed [COORD_BITS:0] xs, ys;

	always_comb begin
		h[0] = $signed(cfg.row0_xy[31:0] & KEEP);
		h[1] = $signed(cfg.row0_xy[63:32] & KEEP);
		h[2] = $signed(cfg.row0_t & KEEP);
		h[3] = $signed(cfg.row1_xy[31:0] & KEEP);
		h[4] = $signed(cfg.row1_xy[63:32] & KEEP);
		h[5] = $signed(cfg.row1_t & KEEP);
		h[6] = $signed(cfg.row2_xy[31:0] & KEEP);
		h[7] = $signed(cfg.row2_xy[63:32] & KEEP);
		h[8] = $signed(cfg.row2_t & KEEP);
	end

	assign xs        = $signed({1'b0, src.src_x});
	assign ys        = $signed({1'b0, src.src_y});
	assign adv       = !v_s2 || !q_full;
	assign src_stall = !adv;
	assign push      = v_s2 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= h[0] * xs;
			p_s1[1] <= h[1] * ys;
			p_s1[2] <= h[3] * xs;
			p_s1[3] <= h[4] * ys;
			p_s1[4] <= h[6] * xs;
			p_s1[5] <= h[7] * ys;
			pix_s1  <= src.pixel_value;
			nx_s2   <= SUM_W'(p_s1[0]) + SUM_W'(p_s1[1]) + SUM_W'(h[2]);
			ny_s2   <= SUM_W'(p_s1[2]) + SUM_W'(p_s1[3]) + SUM_W'(h[5]);
			w_s2    <= SUM_W'(p_s1[4]) + SUM_W'(p_s1[5]) + SUM_W'(h[8]);
			pix_s2  <= pix_s1;
		end
	end

	// classify: magnitudes, signs, and quotients too large for a coordinate
	always_comb begin
		entry.nx_mag = nx_s2[SUM_W-1] ? MAG_W'(-nx_s2) : MAG_W'(nx_s2);
		entry.ny_mag = ny_s2[SUM_W-1] ? MAG_W'(-ny_s2) : MAG_W'(ny_s2);
		entry.d_mag  = w_s2[SUM_W-1] ? MAG_W'(-w_s2) : MAG_W'(w_s2);
		entry.negx   = nx_s2[SUM_W-1] ^ w_s2[SUM_W-1];
		entry.negy   = ny_s2[SUM_W-1] ^ w_s2[SUM_W-1];
		entry.wzero  = (w_s2 == '0);
		entry.ovfx   = REM_W'(entry.nx_mag) >= (REM_W'(entry.d_mag) << COORD_BITS);
		entry.ovfy   = REM_W'(entry.ny_mag) >= (REM_W'(entry.d_mag) << COORD_BITS);
		entry.pix    = pix_s2;
	end

endmodule

[hw/rtl/ppfw_queue.sv]
// ----------------------------------------------------------------------------
// ppfw_queue
// Short FIFO between the front and the divider back end.
// ----------------------------------------------------------------------------
module ppfw_queue import ppfw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  wdata,
	input  logic      pop,
	output q_entry_t  rdata,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/ppfw_back.sv]
// ----------------------------------------------------------------------------
// ppfw_back
// Pipelined restoring dividers, one quotient bit per stage, and bounds check.
// ----------------------------------------------------------------------------
module ppfw_back import ppfw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_entry_t  head,
	input  logic      head_valid,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output dst_pix_t  dst
);

	div_stage_t st_in [COORD_BITS+1];
	div_stage_t st_s  [COORD_BITS];
	logic       v_s   [COORD_BITS];
	div_stage_t last;
	logic       adv;
	logic [LIM_W-1:0] lim_w, lim_h;
	logic       en;
	dst_pix_t   dst_q;
	logic       dst_valid_q;

	assign adv = !dst_valid_q || !dst_stall;
	assign pop = adv && head_valid;

	always_comb begin
		st_in[0].rx    = REM_W'(head.nx_mag);
		st_in[0].ry    = REM_W'(head.ny_mag);
		st_in[0].qx    = '0;
		st_in[0].qy    = '0;
		st_in[0].d     = head.d_mag;
		st_in[0].negx  = head.negx;
		st_in[0].negy  = head.negy;
		st_in[0].wzero = head.wzero;
		st_in[0].ovfx  = head.ovfx;
		st_in[0].ovfy  = head.ovfy;
		st_in[0].pix   = head.pix;
	end

	for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
		localparam int B = COORD_BITS - 1 - k;
		div_stage_t       nxt;
		logic [REM_W-1:0] ds;

		always_comb begin
			nxt = st_in[k];
			ds  = REM_W'(st_in[k].d) << B;
			if (st_in[k].rx >= ds) begin
				nxt.rx    = st_in[k].rx - ds;
				nxt.qx[B] = 1'b1;
			end
			if (st_in[k].ry >= ds) begin
				nxt.ry    = st_in[k].ry - ds;
				nxt.qy[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= (k == 0) ? head_valid : v_s[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[k] <= nxt;
			end
		end

		assign st_in[k+1] = st_s[k];
	end

	assign last  = st_in[COORD_BITS];
	assign lim_w = (LIM_W'(cfg.out_width) > (LIM_W'(1) << COORD_BITS)) ?
		(LIM_W'(1) << COORD_BITS) : LIM_W'(cfg.out_width);
	assign lim_h = (LIM_W'(cfg.out_height) > (LIM_W'(1) << COORD_BITS)) ?
		(LIM_W'(1) << COORD_BITS) : LIM_W'(cfg.out_height);

	// a negative quotient is only acceptable when it truncates to zero
	assign en = !last.wzero && !last.ovfx && !last.ovfy
		&& !(last.negx && last.qx != '0) && !(last.negy && last.qy != '0)
		&& (LIM_W'(last.qx) < lim_w) && (LIM_W'(last.qy) < lim_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			dst_valid_q <= v_s[COORD_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_q.dest_x       <= en ? last.qx : '0;
			dst_q.dest_y       <= en ? last.qy : '0;
			dst_q.dest_value   <= en ? last.pix : '0;
			dst_q.write_enable <= en;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst       = dst_q;

endmodule

[hw/rtl/projective_pixel_forward_warp.sv]
// ----------------------------------------------------------------------------
// projective_pixel_forward_warp
// Maps source pixels through a 3x3 homography to destination write requests.
// ----------------------------------------------------------------------------
// Usage:
//   src channel (src_valid / src_stall / src) takes one source pixel per
//   transfer; dst channel (dst_valid / dst_stall / dst) gives exactly one
//   write request per source pixel, in order.
//   cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   coefficient and size registers; cfg_ready is always high. Write it only
//   while no pixel is in flight.
// Throughput: one pixel per cycle, sustained, while dst is not stalled.
// Pipeline: from src transfer to dst_valid a pixel passes two multiply/sum
//   stages, the queue, one divider stage per quotient bit, and the output
//   register. The X/W and Y/W dividers are restoring pipelines sharing the W
//   operand, one bit per stage.
// Stall: a dst stall freezes the divider pipeline; the front keeps taking
//   pixels until the front-to-back queue fills, then raises src_stall.
// Reset: arst_n clears all valid state and restores the identity matrix
//   and a 256x256 output size. No clearing pass.
// ----------------------------------------------------------------------------
`include "projective_pixel_forward_warp_macros.svh"

module projective_pixel_forward_warp import ppfw_pkg::*; #(
	parameter int COEF_BITS   = COEF_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_pix_t              src,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output dst_pix_t              dst
);

	cfg_t      cfg_q;
	logic      q_push, q_pop;
	q_entry_t  q_wdata, q_rdata;
	q_status_t q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row0_xy    <= 64'h0000_0000_4000_0000;
			cfg_q.row0_t     <= '0;
			cfg_q.row1_xy    <= 64'h4000_0000_0000_0000;
			cfg_q.row1_t     <= '0;
			cfg_q.row2_xy    <= '0;
			cfg_q.row2_t     <= 32'h4000_0000;
			cfg_q.out_width  <= SIZE_W'(256);
			cfg_q.out_height <= SIZE_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW0_XY:    cfg_q.row0_xy    <= cfg_data;
				REG_ROW0_T:     cfg_q.row0_t     <= cfg_data[WORD_W-1:0];
				REG_ROW1_XY:    cfg_q.row1_xy    <= cfg_data;
				REG_ROW1_T:     cfg_q.row1_t     <= cfg_data[WORD_W-1:0];
				REG_ROW2_XY:    cfg_q.row2_xy    <= cfg_data;
				REG_ROW2_T:     cfg_q.row2_t     <= cfg_data[WORD_W-1:0];
				REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data[SIZE_W-1:0];
				REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ppfw_front #(
		.COEF_BITS(COEF_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src       (src),
		.q_full    (q_status.full),
		.push      (q_push),
		.entry     (q_wdata)
	);

	ppfw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	ppfw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (q_rdata),
		.head_valid (!q_status.empty),
		.pop        (q_pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst        (dst)
	);

	`PPFW_ASSERT_IMP(a_push_room, q_push, !q_status.full, "push into a full queue")
	`PPFW_ASSERT_NXT(a_push_lands, q_push, !q_status.empty, "pushed entry missing from queue")
	`PPFW_ASSERT_IMP(a_disabled_zero, dst_valid && !dst.write_enable,
		dst.dest_x == '0 && dst.dest_y == '0 && dst.dest_value == '0,
		"disabled write carries nonzero fields")
	`PPFW_ASSERT_IMP(a_in_bounds, dst_valid && dst.write_enable,
		LIM_W'(dst.dest_x) < LIM_W'(cfg_q.out_width) || cfg_q.out_width > SIZE_W'(1 << COORD_BITS),
		"enabled write outside output width")

endmodule

[tb/projective_pixel_forward_warp_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projective_pixel_forward_warp_tb
// Streams source pixels through the homography warp under several matrix and
// size settings and checks every destination write request against a
// bit-accurate projective mapping computed in the bench.
// ----------------------------------------------------------------------------
module projective_pixel_forward_warp_tb;
	import ppfw_pkg::*;

	localparam int LATENCY = COORD_BITS + 3;

	class warp_scoreboard;
		dst_pix_t pending[$];
		int errors;
		int checked;
		int writes;
		logic [63:0] row_xy[3];
		logic [31:0] row_t[3];
		logic [11:0] width, height;

		function void reset_cfg();
			row_xy[0] = 64'h0000_0000_4000_0000;
			row_xy[1] = 64'h4000_0000_0000_0000;
			row_xy[2] = 64'h0;
			row_t[0]  = 32'h0;
			row_t[1]  = 32'h0;
			row_t[2]  = 32'h4000_0000;
			width     = 12'd256;
			height    = 12'd256;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] data);
			case (idx)
				REG_ROW0_XY: row_xy[0] = data;
				REG_ROW0_T: row_t[0] = data[31:0];
				REG_ROW1_XY: row_xy[1] = data;
				REG_ROW1_T: row_t[1] = data[31:0];
				REG_ROW2_XY: row_xy[2] = data;
				REG_ROW2_T: row_t[2] = data[31:0];
				REG_OUT_WIDTH: width = data[11:0];
				REG_OUT_HEIGHT: height = data[11:0];
				default: ;
			endcase
		endfunction

		function longint row_value(int r, longint x, longint y);
			longint a, b, c;
			a = longint'($signed(row_xy[r][31:0]));
			b = longint'($signed(row_xy[r][63:32]));
			c = longint'($signed(row_t[r]));
			return a * x + b * y + c;
		endfunction

		function longint quot_trunc(longint n, longint d);
			longint un, ud, q;
			un = n < 0 ? -n : n;
			ud = d < 0 ? -d : d;
			q = un / ud;
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		function void note_pixel(src_pix_t p);
			longint x, y, hx, hy, hw, dx, dy, wl, hl;
			dst_pix_t e;
			x = p.src_x;
			y = p.src_y;
			hx = row_value(0, x, y);
			hy = row_value(1, x, y);
			hw = row_value(2, x, y);
			wl = width > 2048 ? 2048 : width;
			hl = height > 2048 ? 2048 : height;
			e = '0;
			if (hw != 0) begin
				dx = quot_trunc(hx, hw);
				dy = quot_trunc(hy, hw);
				if (dx >= 0 && dx < wl && dy >= 0 && dy < hl) begin
					e.dest_x = dx[COORD_BITS-1:0];
					e.dest_y = dy[COORD_BITS-1:0];
					e.dest_value = p.pixel_value;
					e.write_enable = 1'b1;
				end
			end
			pending.push_back(e);
		endfunction

		function void check_write(dst_pix_t got);
			dst_pix_t e;
			checked++;
			if (pending.size() == 0) begin
				report_error("write request with no pixel outstanding");
				return;
			end
			e = pending.pop_front();
			if (got.write_enable) writes++;
			if (got.write_enable !== e.write_enable)
				report_error($sformatf("write_enable got %0b exp %0b", got.write_enable,
					e.write_enable));
			if (got.dest_x !== e.dest_x)
				report_error($sformatf("dest_x got %0d exp %0d", got.dest_x, e.dest_x));
			if (got.dest_y !== e.dest_y)
				report_error($sformatf("dest_y got %0d exp %0d", got.dest_y, e.dest_y));
			if (got.dest_value !== e.dest_value)
				report_error($sformatf("dest_value got %h exp %h", got.dest_value,
					e.dest_value));
		endfunction

		function void report_error(string msg);
			errors++;
			if (errors <= 40) $display("ERROR at %0t: %s", $realtime, msg);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic src_valid = 1'b0;
	logic src_stall;
	src_pix_t src = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	dst_pix_t dst;

	warp_scoreboard sb;
	int src_idle_pct = 32;
	int dst_idle_pct = 32;
	int hold_off_cycles = 0;
	int pixels_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	projective_pixel_forward_warp uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.src_valid(src_valid), .src_stall(src_stall), .src(src),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst(dst)
	);

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (dst_valid && !dst_stall) sb.check_write(dst);
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(99) < dst_idle_pct);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [31:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src <= '{src_x: x, src_y: y, pixel_value: v};
		do @(posedge clk); while (src_stall);
		sb.note_pixel(src);
		pixels_sent++;
	endtask

	// drop valid at the edge of the last transfer, then wait for all results
	task automatic drain();
		src_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Q2.30 value in [-2, 2) mostly near small magnitudes
	function automatic logic [31:0] rand_coef(int scale_bits);
		logic [31:0] c;
		c = $urandom();
		return $signed(c) >>> scale_bits;
	endfunction

	task automatic random_pixels(int n);
		repeat (n) begin
			if ($urandom_range(9) < 8)
				send_pixel(11'($urandom_range(300)), 11'($urandom_range(300)), $urandom());
			else
				send_pixel(11'($urandom()), 11'($urandom()), $urandom());
		end
	endtask

	task automatic load_matrix(logic [31:0] h[9], int w, int ht);
		write_reg(REG_ROW0_XY, {h[1], h[0]});
		write_reg(REG_ROW0_T, {32'h0, h[2]});
		write_reg(REG_ROW1_XY, {h[4], h[3]});
		write_reg(REG_ROW1_T, {32'h0, h[5]});
		write_reg(REG_ROW2_XY, {h[7], h[6]});
		write_reg(REG_ROW2_T, {32'h0, h[8]});
		write_reg(REG_OUT_WIDTH, {32'h0, w[31:0]});
		write_reg(REG_OUT_HEIGHT, {32'h0, ht[31:0]});
	endtask

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [31:0] h[9];
		sb = new();
		sb.reset_cfg();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity at reset: corners, all-ones value, out-of-bounds
		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_pixel(0, 0, 32'hFFFF_FFFF);
		send_pixel(255, 255, 32'h0);
		send_pixel(256, 0, 32'h1234_5678);
		send_pixel(0, 256, 32'h5555_AAAA);
		send_pixel(2047, 2047, 32'hAAAA_5555);
		send_pixel(11'h555, 11'h2AA, 32'hDEAD_BEEF);
		send_pixel(11'h2AA, 11'h555, 32'h8000_0001);
		drain();

		// negative fraction truncates to zero; W negative flips signs
		h = '{32'hE000_0000, 0, 0, 0, 32'hC000_0000, 0, 0, 0, 32'hC000_0000};
		load_matrix(h, 2048, 2048);
		send_pixel(1, 1, 32'h1);
		send_pixel(0, 0, 32'h2);
		send_pixel(2047, 2047, 32'h3);
		send_pixel(1000, 3, 32'h4);
		drain();

		// W zero everywhere, zero and oversize sizes, and an unused register index
		h = '{32'h4000_0000, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 0};
		load_matrix(h, 256, 256);
		send_pixel(5, 5, 32'h77);
		send_pixel(0, 0, 32'h78);
		drain();
		h[8] = 32'h4000_0000;
		load_matrix(h, 0, 4095);
		send_pixel(0, 0, 32'h79);
		send_pixel(3, 3, 32'h7A);
		drain();
		load_matrix(h, 4095, 1);
		send_pixel(2047, 0, 32'h7B);
		send_pixel(2047, 1, 32'h7C);
		send_pixel(0, 0, 32'h7D);
		drain();
		write_reg(reg_idx_t'(4'd9), 64'hFFFF);
		send_pixel(1, 0, 32'h7E);
		drain();

		// random phases, first one with no idling
		for (int ph = 0; ph < 8; ph++) begin
			src_idle_pct = (ph == 0) ? 0 : 32;
			dst_idle_pct = (ph == 0) ? 0 : 32;
			for (int i = 0; i < 9; i++) h[i] = rand_coef($urandom_range(2, 8));
			if (ph % 2) begin
				h[6] = rand_coef(14);
				h[7] = rand_coef(14);
			end else begin
				h[6] = 0;
				h[7] = 0;
			end
			h[8] = (ph == 7) ? 32'h8000_0000 : 32'h4000_0000 + rand_coef(4);
			load_matrix(h, (ph == 3) ? 1 : $urandom_range(1, 2048),
				(ph == 5) ? 2048 : $urandom_range(1, 2048));
			if (ph == 2) begin
				hold_off_cycles = 120;
				random_pixels(30);
				drain();
			end
			if (ph == 4) begin
				random_pixels(40);
				// pause the sender until all results are back
				drain();
			end
			random_pixels(90);
			drain();
		end

		$display("Sent %0d pixels, checked %0d results, %0d with write enabled.",
			pixels_sent, sb.checked, sb.writes);
		$display("Covered identity, negative W, zero W, zero/oversize bounds, random matrices.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ppfw_pkg.sv
hw/rtl/ppfw_front.sv
hw/rtl/ppfw_queue.sv
hw/rtl/ppfw_back.sv
hw/rtl/projective_pixel_forward_warp.sv
tb/projective_pixel_forward_warp_tb.sv
